@@ hdl/ssc_pkg.sv @@
package ssc_pkg;

  localparam int NUM_TYPES   = 4;
  localparam int MAX_ENTRIES = 256;
  localparam int TYPE_W      = 2;
  localparam int ENT_W       = 8;
  localparam int DATA_W      = 32;
  localparam int CNT_W       = 9;
  localparam int ADDR_W      = TYPE_W + ENT_W;
  localparam int DEPTH       = NUM_TYPES * MAX_ENTRIES;
  localparam int REG_W       = 3;
  localparam int OP_W        = 2;
  localparam int ST_W        = 3;

  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_BAD_TYPE = 3'd1;
  localparam logic [ST_W-1:0] ST_ABSENT   = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd3;
  localparam logic [ST_W-1:0] ST_INVALID  = 3'd4;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RDS  = 6'b000010,
    S_CHK  = 6'b000100,
    S_MOV  = 6'b001000,
    S_DONE = 6'b010000,
    S_CLR  = 6'b100000
  } state_e;

  typedef struct packed {
    logic clr;       // write one sparse link of the clearing pass
    logic cap;       // latch request, read sparse link
    logic rd_slot;   // read owner and data at linked slot
    logic upd;       // decide, commit table writes, build result
    logic rd_last;   // read owner and data at last slot
    logic mov;       // move last entry into freed slot
    logic res_load;  // push result to output register
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic need_move;
    logic out_free;
  } sts_t;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic              present;
    logic [DATA_W-1:0] data;
    logic [ENT_W-1:0]  slot;
  } res_t;

endpackage

@@ hdl/sparse_set_component_store.sv @@
// channel | direction | handshake              | payload
// in      | input     | in_valid_i / in_ready_o | operation, type, entity, valid, data
// out     | output    | out_valid_o/out_ready_i | status, present, data_out, dense_slot
// cfg     | input     | cfg_valid_i/cfg_ready_o | registered_types
//
// Each step is one registered read or write of the link and data RAMs: capture
// with the sparse-link read, slot read, commit, and a move into the freed slot
// for a remove that moves the last entry. The result waits in an output register
// and no new request is taken before it is loaded there; a stalled output holds
// the block until that register frees up. Reset clears the fill counts and the
// type register, then a pass zeroes every sparse link before the first request.
module sparse_set_component_store (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [ssc_pkg::OP_W-1:0]       operation_i,
  input  logic [ssc_pkg::TYPE_W-1:0]     component_type_i,
  input  logic [ssc_pkg::ENT_W-1:0]      entity_index_i,
  input  logic                           entity_valid_i,
  input  logic [ssc_pkg::DATA_W-1:0]     component_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [ssc_pkg::ST_W-1:0]       status_o,
  output logic                           present_o,
  output logic [ssc_pkg::DATA_W-1:0]     data_out_o,
  output logic [ssc_pkg::ENT_W-1:0]      dense_slot_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ssc_pkg::REG_W-1:0]      cfg_data_i
);

  ssc_pkg::cmd_t cmd;
  ssc_pkg::sts_t sts;
  ssc_pkg::res_t res;

  assign cfg_ready_o = 1'b1;

  ssc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ssc_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .op_i        (operation_i),
    .type_i      (component_type_i),
    .ent_i       (entity_index_i),
    .ent_valid_i (entity_valid_i),
    .data_i      (component_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_o       (res)
  );

  assign status_o     = res.status;
  assign present_o    = res.present;
  assign data_out_o   = res.data;
  assign dense_slot_o = res.slot;

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while a request is in flight");

  a_present_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && present_o |-> status_o == ssc_pkg::ST_OK)
    else $error("present flagged on a failed request");

  a_data_only_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (data_out_o != '0) |-> present_o)
    else $error("data returned without a hit");
`endif

endmodule

@@ hdl/ssc_ram.sv @@
module ssc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/ssc_ctrl.sv @@
module ssc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ssc_pkg::sts_t sts_i,
  output ssc_pkg::cmd_t cmd_o
);

  ssc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ssc_pkg::S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ssc_pkg::S_CLR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_done) begin
          state_d = ssc_pkg::S_IDLE;
        end
      end
      ssc_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = ssc_pkg::S_RDS;
        end
      end
      ssc_pkg::S_RDS: begin
        cmd_o.rd_slot = 1'b1;
        state_d       = ssc_pkg::S_CHK;
      end
      ssc_pkg::S_CHK: begin
        cmd_o.upd = 1'b1;
        if (sts_i.need_move) begin
          cmd_o.rd_last = 1'b1;
          state_d       = ssc_pkg::S_MOV;
        end else begin
          state_d = ssc_pkg::S_DONE;
        end
      end
      ssc_pkg::S_MOV: begin
        cmd_o.mov = 1'b1;
        state_d   = ssc_pkg::S_DONE;
      end
      ssc_pkg::S_DONE: begin
        // hold the result until the output register frees up
        if (sts_i.out_free) begin
          cmd_o.res_load = 1'b1;
          state_d        = ssc_pkg::S_IDLE;
        end
      end
      default: state_d = ssc_pkg::S_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == ssc_pkg::S_IDLE);

endmodule

@@ hdl/ssc_datapath.sv @@
module ssc_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ssc_pkg::cmd_t                 cmd_i,
  output ssc_pkg::sts_t                 sts_o,
  input  logic                          cfg_we_i,
  input  logic [ssc_pkg::REG_W-1:0]     cfg_data_i,
  input  logic [ssc_pkg::OP_W-1:0]      op_i,
  input  logic [ssc_pkg::TYPE_W-1:0]    type_i,
  input  logic [ssc_pkg::ENT_W-1:0]     ent_i,
  input  logic                          ent_valid_i,
  input  logic [ssc_pkg::DATA_W-1:0]    data_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output ssc_pkg::res_t                 out_o
);

  localparam int AW = ssc_pkg::ADDR_W;
  localparam int EW = ssc_pkg::ENT_W;
  localparam int CW = ssc_pkg::CNT_W;

  logic [ssc_pkg::REG_W-1:0]  types_q;
  logic [ssc_pkg::OP_W-1:0]   op_q;
  logic [ssc_pkg::TYPE_W-1:0] t_q;
  logic [EW-1:0]              e_q;
  logic                       ev_q;
  logic [ssc_pkg::DATA_W-1:0] d_q;
  logic [EW-1:0]              s_q;
  logic [CW-1:0]              cnt_q [ssc_pkg::NUM_TYPES];
  ssc_pkg::res_t              res_q, res_d, out_q;
  logic                       out_valid_q;
  logic [AW-1:0]              clr_q;

  logic [EW-1:0]              sparse_rd, owner_rd;
  logic [ssc_pkg::DATA_W-1:0] dense_rd;
  logic                       sparse_we, owner_we, dense_we, obuf_re;
  logic [AW-1:0]              sparse_wa, owner_wa, dense_wa, obuf_ra;
  logic [EW-1:0]              sparse_wd, owner_wd;
  logic [ssc_pkg::DATA_W-1:0] dense_wd;

  logic [CW-1:0] cnt, last;
  logic          bad_type, bad_ent, live, holds, full, is_add, is_rem, add_new, add_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      types_q     <= '0;
      out_valid_q <= 1'b0;
      clr_q       <= '0;
      for (int i = 0; i < ssc_pkg::NUM_TYPES; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        types_q <= cfg_data_i;
      end
      if (cmd_i.clr) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cmd_i.res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.upd && add_new) begin
        cnt_q[t_q] <= cnt + CW'(1);
      end else if (cmd_i.upd && is_rem && holds) begin
        cnt_q[t_q] <= last;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      op_q <= op_i;
      t_q  <= type_i;
      e_q  <= ent_i;
      ev_q <= ent_valid_i;
      d_q  <= data_i;
    end
    if (cmd_i.rd_slot) begin
      s_q <= sparse_rd;
    end
    if (cmd_i.upd) begin
      res_q <= res_d;
    end
    if (cmd_i.res_load) begin
      out_q <= res_q;
    end
  end

  assign cnt      = cnt_q[t_q];
  assign last     = cnt - CW'(1);
  assign bad_type = ({1'b0, t_q} >= types_q);
  assign bad_ent  = !ev_q;
  assign live     = (op_q != ssc_pkg::OP_NONE) && !bad_type && !bad_ent;
  assign holds    = ({1'b0, s_q} < cnt) && (owner_rd == e_q);
  assign full     = (cnt >= CW'(ssc_pkg::MAX_ENTRIES));
  assign is_add   = live && (op_q == ssc_pkg::OP_ADD);
  assign is_rem   = live && (op_q == ssc_pkg::OP_REMOVE);
  assign add_hit  = is_add && holds;
  assign add_new  = is_add && !holds && !full;

  assign sts_o.clr_done  = &clr_q;
  assign sts_o.need_move = is_rem && holds && (s_q != last[EW-1:0]);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    res_d = '0;
    priority if (op_q == ssc_pkg::OP_NONE) begin
      res_d = '0;
    end else if (bad_type) begin
      res_d.status = ssc_pkg::ST_BAD_TYPE;
    end else if (bad_ent) begin
      res_d.status = ssc_pkg::ST_INVALID;
    end else if (op_q == ssc_pkg::OP_ADD) begin
      if (holds) begin
        res_d.present = 1'b1;
        res_d.slot    = s_q;
      end else if (full) begin
        res_d.status = ssc_pkg::ST_FULL;
      end else begin
        res_d.slot = cnt[EW-1:0];
      end
    end else if (!holds) begin
      res_d.status = ssc_pkg::ST_ABSENT;
    end else begin
      res_d.present = 1'b1;
      res_d.slot    = s_q;
      if (op_q == ssc_pkg::OP_LOOKUP) begin
        res_d.data = dense_rd;
      end
    end
  end

  // write ports: clearing pass, commit of an add, or the move of a swap-remove
  always_comb begin
    dense_we  = (cmd_i.upd && (add_hit || add_new)) || cmd_i.mov;
    owner_we  = (cmd_i.upd && add_new) || cmd_i.mov;
    sparse_we = owner_we || cmd_i.clr;
    if (cmd_i.mov) begin
      dense_wa  = {t_q, s_q};
      dense_wd  = dense_rd;
      owner_wa  = {t_q, s_q};
      owner_wd  = owner_rd;
      sparse_wa = {t_q, owner_rd};
      sparse_wd = s_q;
    end else begin
      dense_wa  = add_hit ? {t_q, s_q} : {t_q, cnt[EW-1:0]};
      dense_wd  = d_q;
      owner_wa  = {t_q, cnt[EW-1:0]};
      owner_wd  = e_q;
      sparse_wa = {t_q, e_q};
      sparse_wd = cnt[EW-1:0];
    end
    if (cmd_i.clr) begin
      sparse_wa = clr_q;
      sparse_wd = '0;
    end
    obuf_re = cmd_i.rd_slot || cmd_i.rd_last;
    obuf_ra = cmd_i.rd_last ? {t_q, last[EW-1:0]} : {t_q, sparse_rd};
  end

  ssc_ram #(.WIDTH(EW), .DEPTH(ssc_pkg::DEPTH)) u_sparse (
    .clk_i   (clk_i),
    .we_i    (sparse_we),
    .waddr_i (sparse_wa),
    .wdata_i (sparse_wd),
    .re_i    (cmd_i.cap),
    .raddr_i ({type_i, ent_i}),
    .rdata_o (sparse_rd)
  );

  ssc_ram #(.WIDTH(EW), .DEPTH(ssc_pkg::DEPTH)) u_owner (
    .clk_i   (clk_i),
    .we_i    (owner_we),
    .waddr_i (owner_wa),
    .wdata_i (owner_wd),
    .re_i    (obuf_re),
    .raddr_i (obuf_ra),
    .rdata_o (owner_rd)
  );

  ssc_ram #(.WIDTH(ssc_pkg::DATA_W), .DEPTH(ssc_pkg::DEPTH)) u_dense (
    .clk_i   (clk_i),
    .we_i    (dense_we),
    .waddr_i (dense_wa),
    .wdata_i (dense_wd),
    .re_i    (obuf_re),
    .raddr_i (obuf_ra),
    .rdata_o (dense_rd)
  );

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

@@ test/sparse_set_component_store_tb.sv @@
`timescale 1ns / 1ps

module sparse_set_component_store_tb;
  import ssc_pkg::*;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [TYPE_W-1:0] ctype;
    logic [ENT_W-1:0]  ent;
    logic              alive;
    logic [DATA_W-1:0] data;
  } req_t;

  typedef struct {
    req_t req;
    logic chk;   // typed-in expectation present
    res_t res;
  } row_t;

  localparam int CYCLE_LIMIT = 2000000;
  localparam logic [CNT_W-1:0] LINK_NONE = CNT_W'(MAX_ENTRIES);

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [OP_W-1:0] operation_i = '0;
  logic [TYPE_W-1:0] component_type_i = '0;
  logic [ENT_W-1:0] entity_index_i = '0;
  logic entity_valid_i = 1'b0;
  logic [DATA_W-1:0] component_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [ST_W-1:0] status_o;
  logic present_o;
  logic [DATA_W-1:0] data_out_o;
  logic [ENT_W-1:0] dense_slot_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [REG_W-1:0] cfg_data_i = '0;

  always #1 clk_i = ~clk_i;

  sparse_set_component_store u_top (.*);

  // store mirror
  logic [CNT_W-1:0]  sparse_tbl [NUM_TYPES][MAX_ENTRIES];
  logic [CNT_W-1:0]  owner_tbl  [NUM_TYPES][MAX_ENTRIES];
  logic [DATA_W-1:0] data_tbl   [NUM_TYPES][MAX_ENTRIES];
  logic [CNT_W-1:0]  fill       [NUM_TYPES];
  logic [REG_W-1:0]  num_types;

  res_t pending_res [$];
  int   errors = 0;
  int   cycles = 0;
  int   snd_idle = 0;
  int   rcv_idle = 0;
  int   n_res = 0;

  function automatic bit holds(int t, int e);
    logic [CNT_W-1:0] s;
    s = sparse_tbl[t][e];
    if (s == LINK_NONE || s >= fill[t]) return 0;
    return owner_tbl[t][s] == CNT_W'(e);
  endfunction

  function automatic res_t apply_request(req_t r);
    res_t o;
    int t, e, s, last, moved;
    o = '0;
    t = r.ctype;
    e = r.ent;
    if (r.op == OP_NONE) return o;
    if (t >= num_types || t >= NUM_TYPES) begin
      o.status = ST_BAD_TYPE;
    end else if (!r.alive) begin
      o.status = ST_INVALID;
    end else if (r.op == OP_ADD) begin
      if (holds(t, e)) begin
        s = sparse_tbl[t][e];
        data_tbl[t][s] = r.data;
        o.present = 1'b1;
        o.slot = ENT_W'(s);
      end else if (fill[t] >= MAX_ENTRIES) begin
        o.status = ST_FULL;
      end else begin
        s = fill[t];
        data_tbl[t][s] = r.data;
        owner_tbl[t][s] = CNT_W'(e);
        sparse_tbl[t][e] = CNT_W'(s);
        fill[t] = CNT_W'(s + 1);
        o.slot = ENT_W'(s);
      end
    end else if (!holds(t, e)) begin
      o.status = ST_ABSENT;
    end else if (r.op == OP_REMOVE) begin
      s = sparse_tbl[t][e];
      last = fill[t] - 1;
      if (s != last) begin
        moved = owner_tbl[t][last];
        data_tbl[t][s] = data_tbl[t][last];
        owner_tbl[t][s] = CNT_W'(moved);
        if (moved < MAX_ENTRIES) sparse_tbl[t][moved] = CNT_W'(s);
      end
      sparse_tbl[t][e] = LINK_NONE;
      owner_tbl[t][last] = LINK_NONE;
      fill[t] = CNT_W'(last);
      o.present = 1'b1;
      o.slot = ENT_W'(s);
    end else begin
      s = sparse_tbl[t][e];
      o.present = 1'b1;
      o.data = data_tbl[t][s];
      o.slot = ENT_W'(s);
    end
    return o;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0h expected %0h (result %0d)", what, got, want, n_res);
    errors++;
  endtask

  // receiver and checker
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && out_valid_o && out_ready_i) begin
      res_t w;
      n_res <= n_res + 1;
      if (pending_res.size() == 0) begin
        $display("unexpected result %0d", n_res);
        errors++;
      end else begin
        w = pending_res.pop_front();
        if (status_o !== w.status) report_mismatch("status", status_o, w.status);
        if (present_o !== w.present) report_mismatch("present", present_o, w.present);
        if (data_out_o !== w.data) report_mismatch("data_out", data_out_o, w.data);
        if (dense_slot_o !== w.slot) report_mismatch("dense_slot", dense_slot_o, w.slot);
      end
    end
  end

  always @(negedge clk_i)
    out_ready_i <= ($urandom_range(99) >= rcv_idle);

  always @(posedge clk_i)
    if (cycles > CYCLE_LIMIT) begin
      $display("sparse_set_component_store test failed");
      $finish;
    end

  task automatic send(req_t r, bit chk = 0, res_t want = '0);
    res_t p;
    @(negedge clk_i);
    while ($urandom_range(99) < snd_idle) @(negedge clk_i);
    in_valid_i <= 1'b1;
    {operation_i, component_type_i, entity_index_i, entity_valid_i, component_data_i} <= r;
    do @(posedge clk_i); while (!in_ready_o);
    p = apply_request(r);
    if (chk && p != want) begin
      $display("predictor disagrees with table row");
      errors++;
    end
    pending_res.push_back(p);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_types(logic [REG_W-1:0] v);
    drain();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    num_types = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic req_t rand_req(int types_hi, int ent_hi);
    req_t r;
    int k;
    k = $urandom_range(99);
    r.op = (k < 45) ? OP_ADD : (k < 70) ? OP_REMOVE : (k < 97) ? OP_LOOKUP : OP_NONE;
    r.ctype = TYPE_W'($urandom_range(types_hi));
    r.ent = ENT_W'($urandom_range(ent_hi));
    r.alive = ($urandom_range(19) != 0);
    r.data = $urandom();
    return r;
  endfunction

  function automatic res_t mk(logic [ST_W-1:0] st);
    res_t o;
    o = '0;
    o.status = st;
    return o;
  endfunction

  row_t rows [$];

  initial begin
    int phase;
    for (int t = 0; t < NUM_TYPES; t++) begin
      fill[t] = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        sparse_tbl[t][i] = LINK_NONE;
        owner_tbl[t][i] = LINK_NONE;
        data_tbl[t][i] = '0;
      end
    end
    num_types = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // after reset no type is registered
    rows.push_back('{'{OP_ADD, 2'd0, 8'd0, 1'b1, 32'h1}, 1, mk(ST_BAD_TYPE)});
    rows.push_back('{'{OP_NONE, 2'd3, 8'hff, 1'b1, '1}, 1, mk(ST_OK)});
    foreach (rows[i]) send(rows[i].req, rows[i].chk, rows[i].res);
    rows.delete();

    write_types(3'd3);
    rows.push_back('{'{OP_ADD, 2'd3, 8'd5, 1'b1, 32'h5}, 1, mk(ST_BAD_TYPE)});
    rows.push_back('{'{OP_ADD, 2'd0, 8'd5, 1'b0, 32'h5}, 1, mk(ST_INVALID)});
    rows.push_back('{'{OP_LOOKUP, 2'd0, 8'd5, 1'b1, 32'h0}, 1, mk(ST_ABSENT)});
    rows.push_back('{'{OP_REMOVE, 2'd1, 8'd7, 1'b1, 32'h0}, 1, mk(ST_ABSENT)});
    rows.push_back('{'{OP_ADD, 2'd0, 8'd0, 1'b1, 32'hffffffff}, 0, '0});
    rows.push_back('{'{OP_ADD, 2'd0, 8'd255, 1'b1, 32'h0}, 0, '0});
    rows.push_back('{'{OP_ADD, 2'd0, 8'd77, 1'b1, 32'hA5A5A5A5}, 0, '0});
    rows.push_back('{'{OP_ADD, 2'd0, 8'd0, 1'b1, 32'h5A5A5A5A}, 0, '0});
    rows.push_back('{'{OP_LOOKUP, 2'd0, 8'd0, 1'b1, 32'h0}, 0, '0});
    rows.push_back('{'{OP_REMOVE, 2'd0, 8'd0, 1'b1, 32'h0}, 0, '0});
    rows.push_back('{'{OP_LOOKUP, 2'd0, 8'd77, 1'b1, 32'h0}, 0, '0});
    rows.push_back('{'{OP_REMOVE, 2'd0, 8'd77, 1'b0, 32'h0}, 1, mk(ST_INVALID)});
    rows.push_back('{'{OP_REMOVE, 2'd0, 8'd77, 1'b1, 32'h0}, 0, '0});
    rows.push_back('{'{OP_LOOKUP, 2'd0, 8'd255, 1'b1, 32'h0}, 0, '0});
    rows.push_back('{'{OP_ADD, 2'd2, 8'd128, 1'b1, 32'h80000001}, 0, '0});
    rows.push_back('{'{OP_NONE, 2'd2, 8'd128, 1'b1, 32'h0}, 1, mk(ST_OK)});
    foreach (rows[i]) send(rows[i].req, rows[i].chk, rows[i].res);

    // fill types 1 and 3 to capacity, overwrite while full, then remove and re-add
    for (int i = 0; i < MAX_ENTRIES; i++) send('{OP_ADD, 2'd1, ENT_W'(i), 1'b1, $urandom()});
    send('{OP_ADD, 2'd0, 8'd1, 1'b1, 32'h1});
    write_types(3'd4);
    for (int i = 0; i < MAX_ENTRIES; i++) send('{OP_ADD, 2'd3, ENT_W'(i), 1'b1, $urandom()});
    send('{OP_ADD, 2'd3, 8'd9, 1'b1, 32'h0});
    send('{OP_ADD, 2'd1, 8'd9, 1'b1, 32'h0});  // overwrite while full
    for (int i = 0; i < 40; i++) send('{OP_REMOVE, 2'd3, ENT_W'($urandom_range(255)), 1'b1, 0});
    send('{OP_ADD, 2'd3, 8'd200, 1'b1, 32'h7});
    send('{OP_ADD, 2'd3, 8'd201, 1'b1, 32'h7});

    // random, three idling phases with a register write before each
    for (phase = 0; phase < 3; phase++) begin
      snd_idle = (phase == 0) ? 25 : (phase == 1) ? 76 : 0;
      rcv_idle = (phase == 0) ? 76 : (phase == 1) ? 25 : 0;
      write_types((phase == 0) ? 3'd2 : (phase == 1) ? 3'd4 : 3'd7);
      for (int i = 0; i < 370; i++)
        send(rand_req(3, (i % 3 == 0) ? 255 : 15));
    end
    write_types(3'd1);
    for (int i = 0; i < 20; i++) send(rand_req(3, 15));

    drain();
    if (errors == 0 && pending_res.size() == 0) begin
      $display("sparse_set_component_store test passed");
    end else begin
      $display("sparse_set_component_store test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/ssc_pkg.sv
hdl/ssc_ram.sv
hdl/ssc_ctrl.sv
hdl/ssc_datapath.sv
hdl/sparse_set_component_store.sv
test/sparse_set_component_store_tb.sv
